### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker file of this project.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every edge, reset included.
`define SBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/sbc_pkg.sv
// Shared types and constants of the sprite blitter with collision detect.
// No dependencies.
package sbc_pkg;

    localparam int ScreenWidthDef  = 256;
    localparam int ScreenHeightDef = 128;
    localparam int SpriteMax       = 64;
    localparam int CoordW          = 14;

    localparam logic [1:0] ActBlit  = 2'd0;
    localparam logic [1:0] ActRead  = 2'd1;
    localparam logic [1:0] ActClear = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic [5:0]         offset_x;
        logic [5:0]         offset_y;
        logic               ink;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic collision;
        logic pixel_value;
    } t_out_beat;

    // Write request from the update stage to the framebuffer.
    typedef struct packed {
        logic en;
        logic data;
    } t_fb_wr;

endpackage

### hw/rtl/sprite_blit_with_collision_top.sv
// Channel  Direction  Handshake             Payload
// in       sink       i_in_valid/o_in_stall  i_in_data  (sbc_pkg::t_in_beat)
// out      source     o_out_valid/i_out_stall o_out_data (sbc_pkg::t_out_beat)
//
// One beat per cycle while no stall or clear sweep holds the input; a result reaches
// o_out_valid through s1, the framebuffer read in s2, then the output register.
// The single-port-write framebuffer memory sets the rate: one read and one
// write per cycle, same-pixel overlap covered by forwarding.
// After reset the framebuffer is swept to zero, all SCREEN_WIDTH*SCREEN_HEIGHT bits
// (32768 at default size), with o_in_stall high throughout.
// A stalled output beat holds the pipeline and sets o_in_stall, as the clear sweep does.
// Depends on sbc_pkg, sbc_addr, sbc_fbmem.
module sprite_blit_with_collision_top #(
    parameter int SCREEN_WIDTH  = sbc_pkg::ScreenWidthDef,
    parameter int SCREEN_HEIGHT = sbc_pkg::ScreenHeightDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sbc_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sbc_pkg::t_out_beat o_out_data
);
    import sbc_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PW    = $clog2(DEPTH);

    logic          en;
    logic          accept;
    logic          clr_busy;
    logic          a_hit;
    logic [PW-1:0] a_pos;

    logic          r_s1_valid;
    logic [1:0]    r_s1_action;
    logic          r_s1_hit;
    logic [PW-1:0] r_s1_pos;
    logic          r_s1_last;

    logic          r_s2_valid;
    logic [1:0]    r_s2_action;
    logic          r_s2_hit;
    logic [PW-1:0] r_s2_pos;
    logic          r_s2_last;
    logic          r_fwd_hit;
    logic          r_fwd_val;

    logic          r_coll;
    logic          r_out_valid;
    t_out_beat     r_out_data;

    logic          rd_data;
    logic          cur_bit;
    logic          s2_blit;
    logic          s2_read;
    logic          coll_total;
    logic          s2_result;
    t_fb_wr        fb_wr;
    t_out_beat     n_out_data;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en || clr_busy;
    assign accept     = i_in_valid && !o_in_stall;

    sbc_addr #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .PW           (PW)
    ) u_addr (
        .i_beat(i_in_data),
        .o_hit (a_hit),
        .o_pos (a_pos)
    );

    sbc_fbmem #(
        .DEPTH(DEPTH),
        .AW   (PW)
    ) u_fbmem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (en),
        .i_rd_addr(r_s1_pos),
        .o_rd_data(rd_data),
        .i_wr     (fb_wr),
        .i_wr_addr(r_s2_pos),
        .o_busy   (clr_busy)
    );

    always_comb begin
        s2_blit    = (r_s2_action == ActBlit);
        s2_read    = (r_s2_action == ActRead);
        // Take the bit written by the beat just ahead when it hit the same pixel.
        cur_bit    = r_fwd_hit ? r_fwd_val : rd_data;
        coll_total = r_coll || (s2_blit && r_s2_hit && cur_bit);
        s2_result  = r_s2_valid && ((s2_blit && r_s2_last) || s2_read);
        fb_wr.en   = en && r_s2_valid && r_s2_hit
                  && (s2_blit || (r_s2_action == ActClear));
        fb_wr.data = s2_blit;
        n_out_data.collision   = s2_blit && coll_total;
        n_out_data.pixel_value = s2_read && r_s2_hit && cur_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_coll      <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= s2_result;
            if (r_s2_valid && s2_blit) begin
                r_coll <= !r_s2_last && coll_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_action <= i_in_data.action;
            r_s1_hit    <= a_hit;
            r_s1_pos    <= a_pos;
            r_s1_last   <= i_in_data.last;
            r_s2_action <= r_s1_action;
            r_s2_hit    <= r_s1_hit;
            r_s2_pos    <= r_s1_pos;
            r_s2_last   <= r_s1_last;
            r_fwd_hit   <= fb_wr.en && (r_s2_pos == r_s1_pos);
            r_fwd_val   <= fb_wr.data;
            r_out_data  <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hw/rtl/sbc_addr.sv
// Screen coordinate, clipping and bit address for one input beat.
// Depends on sbc_pkg.
module sbc_addr #(
    parameter int SCREEN_WIDTH  = sbc_pkg::ScreenWidthDef,
    parameter int SCREEN_HEIGHT = sbc_pkg::ScreenHeightDef,
    parameter int PW            = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT)
) (
    input  sbc_pkg::t_in_beat i_beat,
    output logic              o_hit,
    output logic [PW-1:0]     o_pos
);
    import sbc_pkg::*;

    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);

    logic              is_blit;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic              on_screen;
    logic              in_sprite;
    logic [PW-1:0]     y_ext;

    always_comb begin
        is_blit = (i_beat.action == ActBlit);
        // Read and clear use the origin as an absolute position.
        x = CoordW'(i_beat.origin_x) + (is_blit ? CoordW'(i_beat.offset_x) : '0);
        y = CoordW'(i_beat.origin_y) + (is_blit ? CoordW'(i_beat.offset_y) : '0);
        on_screen = !x[CoordW-1] && (x < $signed(CoordW'(SCREEN_WIDTH)))
                 && !y[CoordW-1] && (y < $signed(CoordW'(SCREEN_HEIGHT)));
        in_sprite = (9'(i_beat.offset_x) < 9'(SpriteMax))
                 && (9'(i_beat.offset_y) < 9'(SpriteMax));
        o_hit = on_screen && (!is_blit || (i_beat.ink && in_sprite));
        y_ext = PW'(y[YW-1:0]);
        o_pos = y_ext * PW'(SCREEN_WIDTH) + PW'(x[XW-1:0]);
    end

endmodule

### hw/rtl/sbc_fbmem.sv
// One-bit framebuffer memory with registered read and a clearing sweep after reset.
// Depends on sbc_pkg.
module sbc_fbmem #(
    parameter int DEPTH = sbc_pkg::ScreenWidthDef * sbc_pkg::ScreenHeightDef,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output logic            o_rd_data,
    input  sbc_pkg::t_fb_wr i_wr,
    input  logic [AW-1:0]   i_wr_addr,
    output logic            o_busy
);
    import sbc_pkg::*;

    logic          r_mem [DEPTH];
    logic          r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        wr_en   = r_clr_busy || i_wr.en;
        wr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        wr_data = !r_clr_busy && i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

### hw/rtl/sbc_checker.sv
// Port-level checks for sprite_blit_with_collision_top, bound to it below.
// Depends on sbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbc_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               i_out_stall,
    input logic               o_out_valid,
    input sbc_pkg::t_out_beat o_out_data
);
    import sbc_pkg::*;

    `SBC_ASSERT(a_out_valid_holds, o_out_valid && i_out_stall |=> o_out_valid, "valid dropped while stalled")
    `SBC_ASSERT(a_out_data_holds, o_out_valid && i_out_stall |=> $stable(o_out_data), "stalled beat changed")
    `SBC_ASSERT(a_one_kind, o_out_valid |-> !(o_out_data.collision && o_out_data.pixel_value), "collision and pixel both set")
    `SBC_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> o_in_stall, "input open during clear sweep")
    `SBC_ASSERT_ALWAYS(a_empty_after_reset, !i_rst_n |=> !o_out_valid, "result right after reset")

endmodule

bind sprite_blit_with_collision_top sbc_port_checker u_sbc_checker (.*);
